// ===== rtl/core/pal_pkg.sv =====
// Shared types and constants for the positional array list.
package pal_pkg;

	localparam int KIND_W    = 2;
	localparam int POS_W     = 5;
	localparam int DATA_W    = 32;
	localparam int CAP_W     = 5;
	localparam int STATUS_W  = 2;
	localparam int CNT_OUT_W = 5;
	localparam int TDATA_W   = 40;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [KIND_W-1:0] {
		KIND_FIND   = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_UPDATE = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2,
		CELL_WRITE  = 2'd3
	} cell_op_t;

endpackage

// ===== rtl/core/pal_cell.sv =====
// One entry of the list: holds a word, shifts from its neighbors on insert/delete.
module pal_cell #(
	parameter int IDX        = 0,
	parameter int IDX_W      = 4,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  pal_pkg::cell_op_t     op,
	input  logic [IDX_W-1:0]      target,
	input  logic [VALUE_BITS-1:0] wr_value,
	input  logic [VALUE_BITS-1:0] left_data,
	input  logic [VALUE_BITS-1:0] right_data,
	output logic [VALUE_BITS-1:0] data
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [VALUE_BITS-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			pal_pkg::CELL_INSERT: begin
				if (MY_IDX > target) begin
					data_q <= left_data;
				end else if (MY_IDX == target) begin
					data_q <= wr_value;
				end
			end
			pal_pkg::CELL_DELETE: begin
				if (MY_IDX >= target) begin
					data_q <= right_data;
				end
			end
			pal_pkg::CELL_WRITE: begin
				if (MY_IDX == target) begin
					data_q <= wr_value;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

endmodule

// ===== rtl/core/positional_array_list.sv =====
// Top level of the positional array list: request decode, cell chain, result register.
//
// Usage:
//  - Requests enter on the s_ side (s_tvalid/s_tready/s_tdata). A transfer
//    carries kind (find, insert-after, delete, update), a signed position
//    (-1 = front for insert) and a value.
//  - Each request yields exactly one result on the m_ side: status, the word
//    read by a successful find (else zero), the new count and an empty flag.
//  - Capacity is written on cfg_valid/cfg_data (always ready); values above
//    DEPTH saturate to DEPTH. Write it only while no request is in flight.
// Timing:
//  - One request per cycle while results are being taken. The entries sit in a
//    chain of DEPTH cells; an insert or delete moves every entry past the
//    target one place at once, so the shift never iterates. The result shows
//    on m_tvalid in the cycle after the request transfer.
//  - A stalled result holds in the output register; a new request is taken
//    in the cycle the held result is taken (s_tready = !m_tvalid | m_tready).
// Reset:
//  - arst_n clears the count and the result valid and sets capacity to 16.
//    Cell contents are not cleared; only entries below the count are read.
module positional_array_list #(
	parameter int DEPTH      = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// capacity register write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pal_pkg::CAP_W-1:0]    cfg_data,
	// requests: [1:0] kind, [6:2] position, [38:7] value, [39] zero
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [pal_pkg::TDATA_W-1:0]  s_tdata,
	// results: [1:0] status, [33:2] read_value, [38:34] count, [39] empty_res
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [pal_pkg::TDATA_W-1:0]  m_tdata
);

	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = ((CNT_W > pal_pkg::POS_W) ? CNT_W : pal_pkg::POS_W) + 1;
	localparam int DW     = pal_pkg::DATA_W;

	localparam logic signed [CMP_W-1:0] DEPTH_X    = CMP_W'(DEPTH);
	localparam logic signed [CMP_W-1:0] MINUS_ONE  = '1;
	localparam logic signed [CMP_W-1:0] ZERO_X     = '0;
	localparam logic signed [CMP_W-1:0] ONE_X      = CMP_W'(1);

	// state
	logic [pal_pkg::CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0]          count_q;
	logic                      out_valid_q;
	logic [DW-1:0]             read_value_q;
	pal_pkg::status_t          status_q;
	logic [CMP_W-1:0]          count_out_q;

	// request fields
	pal_pkg::kind_t            kind;
	logic [pal_pkg::POS_W-1:0] position;
	logic [DW-1:0]             value;
	logic                      accept;

	// decode
	logic signed [CMP_W-1:0]   pos_x;
	logic signed [CMP_W-1:0]   cnt_x;
	logic signed [CMP_W-1:0]   cap_x;
	logic signed [CMP_W-1:0]   cap_eff;
	logic signed [CMP_W-1:0]   tgt_x;
	logic signed [CMP_W-1:0]   cnt_nx_x;
	logic                      is_insert;
	logic                      range_bad;
	logic                      full;
	pal_pkg::status_t          status_nx;
	pal_pkg::cell_op_t         cell_op;
	logic [IDX_W-1:0]          target;
	logic [VALUE_BITS-1:0]     wr_value;
	logic [VALUE_BITS-1:0]     cell_data [DEPTH];
	logic [DW-1:0]             sel_value;
	logic [DW-1:0]             read_nx;

	assign kind     = pal_pkg::kind_t'(s_tdata[1:0]);
	assign position = s_tdata[6:2];
	assign value    = s_tdata[38:7];

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;

	always_comb begin
		pos_x     = {{(CMP_W - pal_pkg::POS_W){position[pal_pkg::POS_W-1]}}, position};
		cnt_x     = {{(CMP_W - CNT_W){1'b0}}, count_q};
		cap_x     = {{(CMP_W - pal_pkg::CAP_W){1'b0}}, capacity_q};
		cap_eff   = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
		is_insert = (kind == pal_pkg::KIND_INSERT);
		// insert accepts -1..count-1, the rest 0..count-1
		if (is_insert) begin
			range_bad = (pos_x < MINUS_ONE) || (pos_x >= cnt_x);
		end else begin
			range_bad = (pos_x < ZERO_X) || (pos_x >= cnt_x);
		end
		full = (cnt_x >= cap_eff);
		if (range_bad) begin
			status_nx = pal_pkg::ST_RANGE;
		end else if (is_insert && full) begin
			status_nx = pal_pkg::ST_FULL;
		end else begin
			status_nx = pal_pkg::ST_OK;
		end
		tgt_x  = is_insert ? (pos_x + ONE_X) : pos_x;
		target = tgt_x[IDX_W-1:0];
	end

	always_comb begin
		cell_op  = pal_pkg::CELL_HOLD;
		cnt_nx_x = cnt_x;
		read_nx  = '0;
		if (status_nx == pal_pkg::ST_OK) begin
			case (kind)
				pal_pkg::KIND_INSERT: begin
					cell_op  = pal_pkg::CELL_INSERT;
					cnt_nx_x = cnt_x + ONE_X;
				end
				pal_pkg::KIND_DELETE: begin
					cell_op  = pal_pkg::CELL_DELETE;
					cnt_nx_x = cnt_x - ONE_X;
				end
				pal_pkg::KIND_UPDATE: cell_op = pal_pkg::CELL_WRITE;
				default:              read_nx = sel_value;
			endcase
		end
		if (!accept) begin
			cell_op = pal_pkg::CELL_HOLD;
		end
	end

	// value width adaption between the 32-bit field and the stored word
	generate
		if (VALUE_BITS >= DW) begin : g_wide
			assign wr_value  = VALUE_BITS'(value);
			assign sel_value = cell_data[target][DW-1:0];
		end else begin : g_narrow
			assign wr_value  = value[VALUE_BITS-1:0];
			assign sel_value = {{(DW - VALUE_BITS){1'b0}}, cell_data[target]};
		end
	endgenerate

	// chain of cells; cell i takes from i-1 on insert and from i+1 on delete
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [VALUE_BITS-1:0] left_w;
			logic [VALUE_BITS-1:0] right_w;
			if (gi == 0) begin : g_first
				assign left_w = wr_value;
			end else begin : g_mid_l
				assign left_w = cell_data[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign right_w = cell_data[gi];
			end else begin : g_mid_r
				assign right_w = cell_data[gi+1];
			end
			pal_cell #(
				.IDX        (gi),
				.IDX_W      (IDX_W),
				.VALUE_BITS (VALUE_BITS)
			) u_cell (
				.clk        (clk),
				.op         (cell_op),
				.target     (target),
				.wr_value   (wr_value),
				.left_data  (left_w),
				.right_data (right_w),
				.data       (cell_data[gi])
			);
		end
	endgenerate

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= pal_pkg::CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			if (accept) begin
				count_q     <= cnt_nx_x[CNT_W-1:0];
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_nx;
			read_value_q <= read_nx;
			count_out_q  <= cnt_nx_x;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(count_out_q == ZERO_X),
	                   count_out_q[pal_pkg::CNT_OUT_W-1:0],
	                   read_value_q,
	                   status_q};

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("count above depth");

	a_refused_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status_nx != pal_pkg::ST_OK) |=> $stable(count_q))
		else $error("refused request changed the count");

	a_insert_counts_up: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_insert && status_nx == pal_pkg::ST_OK)
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the count");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !(kind == pal_pkg::KIND_FIND && status_nx == pal_pkg::ST_OK))
		|=> read_value_q == '0)
		else $error("read value nonzero without a successful find");

	a_full_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status_nx == pal_pkg::ST_FULL) |-> (is_insert && !range_bad))
		else $error("full status on a non-insert");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the positional array list: directed table, random requests.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 8;
	localparam int DEPTH           = 16;
	localparam int ITEMS_PER_PHASE = 205;
	localparam int TAIL_CYCLES     = 16;   // idle tail after the last result; this is generous
	localparam int STALL_LIMIT     = 2000; // cycles with no transfer on any channel
	localparam int NUM_STEPS       = 24;
	localparam int NUM_PHASES      = 6;

	// One result as the block reports it.
	typedef struct packed {
		pal_pkg::status_t status;
		logic [31:0]      read_value;
		logic [4:0]       count;
		logic             empty;
	} list_outcome_t;

	// One row of the directed table. A row with new_cap set drains the block and
	// writes cap first. Rows with typed set carry their expected result; the rest
	// take the predictor's.
	typedef struct packed {
		logic           new_cap;
		logic [4:0]     cap;
		pal_pkg::kind_t kind;
		logic [4:0]     pos;
		logic [31:0]    value;
		logic           typed;
		list_outcome_t  outcome;
	} list_step_t;

	// DUT hookup; every input starts at a known value
	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [pal_pkg::CAP_W-1:0]   cfg_data  = '0;
	logic                        s_tvalid  = 1'b0;
	logic                        s_tready;
	// [1:0] kind, [6:2] position, [38:7] value, [39] zero
	logic [pal_pkg::TDATA_W-1:0] s_tdata   = '0;
	logic                        m_tvalid;
	logic                        m_tready  = 1'b0;
	// [1:0] status, [33:2] read_value, [38:34] count, [39] empty
	logic [pal_pkg::TDATA_W-1:0] m_tdata;

	// Shadow of the list as the predictor sees it
	logic [31:0]   entries [DEPTH];
	int            held_count  = 0;
	int            capacity_q  = int'(pal_pkg::CAP_RESET);

	list_outcome_t outcomes_due [$];
	int            mismatches   = 0;
	int            quiet_cycles = 0;
	int            src_idle_pct = 37;
	int            sink_idle_pct = 71;

	// Directed table. -1 is 5'h1f, -16 is 5'h10.
	list_step_t steps [NUM_STEPS] = '{
		// empty list after reset: everything refused, insert at 0 has nothing to follow
		'{1'b0, 5'd0, pal_pkg::KIND_FIND, 5'd0, 32'h0, 1'b1,
			'{pal_pkg::ST_RANGE, 32'h0, 5'd0, 1'b1}},
		'{1'b0, 5'd0, pal_pkg::KIND_DELETE, 5'd0, 32'h0, 1'b1,
			'{pal_pkg::ST_RANGE, 32'h0, 5'd0, 1'b1}},
		'{1'b0, 5'd0, pal_pkg::KIND_UPDATE, 5'h1f, 32'h0, 1'b1,
			'{pal_pkg::ST_RANGE, 32'h0, 5'd0, 1'b1}},
		'{1'b0, 5'd0, pal_pkg::KIND_INSERT, 5'd0, 32'h0, 1'b1,
			'{pal_pkg::ST_RANGE, 32'h0, 5'd0, 1'b1}},
		// capacity zero: always full
		'{1'b1, 5'd0, pal_pkg::KIND_INSERT, 5'h1f, 32'h1, 1'b1,
			'{pal_pkg::ST_FULL, 32'h0, 5'd0, 1'b1}},
		// capacity two: fill at the front with the value extremes
		'{1'b1, 5'd2, pal_pkg::KIND_INSERT, 5'h1f, 32'h7fffffff, 1'b1,
			'{pal_pkg::ST_OK, 32'h0, 5'd1, 1'b0}},
		'{1'b0, 5'd0, pal_pkg::KIND_INSERT, 5'h1f, 32'h80000000, 1'b1,
			'{pal_pkg::ST_OK, 32'h0, 5'd2, 1'b0}},
		'{1'b0, 5'd0, pal_pkg::KIND_INSERT, 5'd1, 32'hffffffff, 1'b1,
			'{pal_pkg::ST_FULL, 32'h0, 5'd2, 1'b0}},
		// bad position into a full list: range wins over full
		'{1'b0, 5'd0, pal_pkg::KIND_INSERT, 5'd2, 32'h1, 1'b1,
			'{pal_pkg::ST_RANGE, 32'h0, 5'd2, 1'b0}},
		'{1'b0, 5'd0, pal_pkg::KIND_FIND, 5'd0, 32'h0, 1'b1,
			'{pal_pkg::ST_OK, 32'h80000000, 5'd2, 1'b0}},
		'{1'b0, 5'd0, pal_pkg::KIND_FIND, 5'd1, 32'h0, 1'b1,
			'{pal_pkg::ST_OK, 32'h7fffffff, 5'd2, 1'b0}},
		// capacity below the count: entries stay, inserts refused
		'{1'b1, 5'd1, pal_pkg::KIND_INSERT, 5'h1f, 32'h13579bdf, 1'b1,
			'{pal_pkg::ST_FULL, 32'h0, 5'd2, 1'b0}},
		'{1'b0, 5'd0, pal_pkg::KIND_FIND, 5'd1, 32'h0, 1'b1,
			'{pal_pkg::ST_OK, 32'h7fffffff, 5'd2, 1'b0}},
		// capacity 31 saturates to the store depth
		'{1'b1, 5'd31, pal_pkg::KIND_INSERT, 5'd1, 32'hffffffff, 1'b1,
			'{pal_pkg::ST_OK, 32'h0, 5'd3, 1'b0}},
		'{1'b0, 5'd0, pal_pkg::KIND_INSERT, 5'd0, 32'h0, 1'b0,
			'{pal_pkg::ST_OK, 32'h0, 5'd0, 1'b0}},
		'{1'b0, 5'd0, pal_pkg::KIND_UPDATE, 5'd1, 32'ha5a55a5a, 1'b0,
			'{pal_pkg::ST_OK, 32'h0, 5'd0, 1'b0}},
		'{1'b0, 5'd0, pal_pkg::KIND_FIND, 5'h10, 32'h0, 1'b1,
			'{pal_pkg::ST_RANGE, 32'h0, 5'd4, 1'b0}},
		'{1'b0, 5'd0, pal_pkg::KIND_FIND, 5'd15, 32'h0, 1'b1,
			'{pal_pkg::ST_RANGE, 32'h0, 5'd4, 1'b0}},
		// deletes at the front and the tail, down to empty
		'{1'b0, 5'd0, pal_pkg::KIND_DELETE, 5'd0, 32'h0, 1'b0,
			'{pal_pkg::ST_OK, 32'h0, 5'd0, 1'b0}},
		'{1'b0, 5'd0, pal_pkg::KIND_DELETE, 5'd2, 32'h0, 1'b0,
			'{pal_pkg::ST_OK, 32'h0, 5'd0, 1'b0}},
		'{1'b0, 5'd0, pal_pkg::KIND_FIND, 5'd1, 32'h0, 1'b0,
			'{pal_pkg::ST_OK, 32'h0, 5'd0, 1'b0}},
		'{1'b0, 5'd0, pal_pkg::KIND_DELETE, 5'd1, 32'h0, 1'b0,
			'{pal_pkg::ST_OK, 32'h0, 5'd0, 1'b0}},
		'{1'b0, 5'd0, pal_pkg::KIND_DELETE, 5'd0, 32'h0, 1'b1,
			'{pal_pkg::ST_OK, 32'h0, 5'd0, 1'b1}},
		'{1'b0, 5'd0, pal_pkg::KIND_DELETE, 5'd0, 32'h0, 1'b1,
			'{pal_pkg::ST_RANGE, 32'h0, 5'd0, 1'b1}}
	};

	positional_array_list DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #CLK_HALF clk = ~clk;

	// Receiver stalls at random; the rate is set per phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Carries out one request on the shadow list and returns what the block
	// must report. Refused requests leave the list untouched.
	function automatic list_outcome_t apply_list_op(pal_pkg::kind_t k, logic [4:0] p,
			logic [31:0] v);
		list_outcome_t r;
		int pos;
		int n;
		int limit;
		int j;
		pos = $signed(p);
		n = held_count;
		limit = (capacity_q > DEPTH) ? DEPTH : capacity_q;
		r.status = pal_pkg::ST_OK;
		r.read_value = '0;
		if (k == pal_pkg::KIND_INSERT) begin
			if (pos < -1 || pos > n - 1) begin
				r.status = pal_pkg::ST_RANGE;
			end else if (n >= limit) begin
				r.status = pal_pkg::ST_FULL;
			end else begin
				for (j = n - 1; j > pos; j--)
					entries[j + 1] = entries[j];
				entries[pos + 1] = v;
				held_count++;
			end
		end else if (pos < 0 || pos > n - 1) begin
			r.status = pal_pkg::ST_RANGE;
		end else begin
			case (k)
				pal_pkg::KIND_FIND: begin
					r.read_value = entries[pos];
				end
				pal_pkg::KIND_DELETE: begin
					for (j = pos + 1; j < n; j++)
						entries[j - 1] = entries[j];
					held_count--;
				end
				default: begin
					entries[pos] = v;
				end
			endcase
		end
		r.count = held_count[4:0];
		r.empty = (held_count == 0);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
	endtask

	// Drives one request, holding it until the transfer, then books its result.
	// Values read right after the edge are the ones the block sampled.
	task automatic send_request(pal_pkg::kind_t k, logic [4:0] p, logic [31:0] v,
			logic typed, list_outcome_t typed_out);
		list_outcome_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, v, p, k};
		do @(posedge clk); while (s_tready !== 1'b1);
		predicted = apply_list_op(k, p, v);
		outcomes_due.push_back(typed ? typed_out : predicted);
	endtask

	// Sender holds off until every booked result has come back.
	task automatic wait_all_outcomes();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outcomes_due.size() != 0);
	endtask

	task automatic write_capacity(logic [4:0] c);
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		capacity_q = c;
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed requests aimed inside the list as it stands, some
	// positions left fully random. Insert outweighs delete, so the list climbs
	// to its capacity and then bounces there.
	task automatic pick_random_request(output pal_pkg::kind_t k, output logic [4:0] p,
			output logic [31:0] v);
		int roll;
		int n;
		roll = $urandom_range(99);
		n = held_count;
		if (roll < 20)
			k = pal_pkg::KIND_FIND;
		else if (roll < 55)
			k = pal_pkg::KIND_INSERT;
		else if (roll < 78)
			k = pal_pkg::KIND_DELETE;
		else
			k = pal_pkg::KIND_UPDATE;
		if ($urandom_range(99) < 12 || (n == 0 && k != pal_pkg::KIND_INSERT))
			p = 5'($urandom_range(31));
		else if (k == pal_pkg::KIND_INSERT)
			p = 5'(int'($urandom_range(n)) - 1);
		else
			p = 5'($urandom_range(n - 1));
		case ($urandom_range(9))
			0: v = 32'h8000_0000;
			1: v = 32'h7fff_ffff;
			2: v = 32'h0;
			3: v = 32'hffff_ffff;
			default: v = $urandom;
		endcase
	endtask

	// Result checker and activity counter for the watchdog.
	always @(posedge clk) begin
		list_outcome_t want;
		logic [31:0]   got_value;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if ($isunknown(m_tvalid))
				report_mismatch("m_tvalid unknown", 32'(m_tvalid), 32'h0);
			if (m_tvalid === 1'b1 && m_tready) begin
				got_value = m_tdata[33:2];
				if (outcomes_due.size() == 0) begin
					report_mismatch("result with none pending", got_value, 32'h0);
				end else begin
					want = outcomes_due.pop_front();
					if (m_tdata[1:0] !== want.status)
						report_mismatch("status", 32'(m_tdata[1:0]), 32'(want.status));
					if (got_value !== want.read_value)
						report_mismatch("read_value", got_value, want.read_value);
					if (m_tdata[38:34] !== want.count)
						report_mismatch("count", 32'(m_tdata[38:34]), 32'(want.count));
					if (m_tdata[39] !== want.empty)
						report_mismatch("empty_res", 32'(m_tdata[39]), 32'(want.empty));
				end
			end
		end
	end

	// Watchdog: too long with no transfer anywhere means a hang.
	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int             i;
		int             ph;
		pal_pkg::kind_t k;
		logic [4:0]     p;
		logic [31:0]    v;
		logic [4:0]     phase_caps [NUM_PHASES];

		// saturating, depth, always full, just above depth, tiny, somewhere mid-range
		phase_caps = '{5'd31, 5'd16, 5'd0, 5'd17, 5'd3, 5'd9};
		phase_caps[5] = 5'($urandom_range(4, 15));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < NUM_STEPS; i++) begin
			if (steps[i].new_cap) begin
				wait_all_outcomes();
				write_capacity(steps[i].cap);
			end
			send_request(steps[i].kind, steps[i].pos, steps[i].value, steps[i].typed,
				steps[i].outcome);
		end

		// random phases; idling goes sender-light, then receiver-light, then none
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph / 2)
				0: begin
					src_idle_pct  = 37;
					sink_idle_pct = 71;
				end
				1: begin
					src_idle_pct  = 71;
					sink_idle_pct = 37;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			wait_all_outcomes();
			write_capacity(phase_caps[ph]);
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				// one mid-stream hold-off until the result queue runs dry
				if (ph == 0 && i == ITEMS_PER_PHASE / 2)
					wait_all_outcomes();
				pick_random_request(k, p, v);
				send_request(k, p, v, 1'b0, '0);
			end
		end

		wait_all_outcomes();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outcomes_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
